[hw/rtl/lrat_pkg.sv]
// Shared types and op codes for the lazy range add/assign segment tree.
package lrat_pkg;

	localparam int DW     = 64;
	localparam int MODE_W = 3;
	localparam int IDX_W  = 11;

	localparam logic [MODE_W-1:0] OP_ADD  = 3'd0;
	localparam logic [MODE_W-1:0] OP_ASG  = 3'd1;
	localparam logic [MODE_W-1:0] OP_QSUM = 3'd2;
	localparam logic [MODE_W-1:0] OP_QMAX = 3'd3;
	localparam logic [MODE_W-1:0] OP_QMIN = 3'd4;

	typedef logic [DW-1:0] word_t;

	typedef struct packed {
		word_t sum;
		word_t mx;
		word_t mn;
		word_t tag;
		word_t aval;
		logic  pend;
	} node_t;

endpackage

[hw/rtl/lrat_req_if.sv]
// Request channel: operation, index range and value.
interface lrat_req_if;
	logic                          valid;
	logic                          ready;
	logic [lrat_pkg::MODE_W-1:0]   mode;
	logic [lrat_pkg::IDX_W-1:0]    left;
	logic [lrat_pkg::IDX_W-1:0]    right;
	logic signed [lrat_pkg::DW-1:0] value;

	modport source(output valid, mode, left, right, value, input ready);
	modport sink(input valid, mode, left, right, value, output ready);
endinterface

[hw/rtl/lrat_rsp_if.sv]
// Response channel: query answer.
interface lrat_rsp_if;
	logic                           valid;
	logic                           ready;
	logic signed [lrat_pkg::DW-1:0] answer;

	modport source(output valid, answer, input ready);
	modport sink(input valid, answer, output ready);
endinterface

[hw/rtl/lrat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lrat_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/lrat_front.sv]
// Front end: accepts items, orders and clamps the range, holds leaf_count.
module lrat_front #(
	parameter int LEAVES = 1024,
	localparam int IW    = $clog2(LEAVES + 1),
	localparam int EW    = lrat_pkg::MODE_W + 2 * IW + lrat_pkg::DW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lrat_req_if.sink                   req,
	input  logic                       cfg_we,
	input  logic [lrat_pkg::IDX_W-1:0] cfg_wdata,
	input  logic                       clr_busy,
	input  logic                       fifo_full,
	output logic                       push,
	output logic [EW-1:0]              push_data,
	output logic [IW-1:0]              leaf_cnt,
	output logic                       clr_start
);
	import lrat_pkg::*;

	localparam int CW      = (IW > IDX_W) ? IW : IDX_W;
	localparam int RST_CNT = (LEAVES < 1024) ? LEAVES : 1024;

	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [IW-1:0]     lft;
		logic [IW-1:0]     rgt;
		word_t             val;
	} entry_t;

	logic [IW-1:0] leaf_cnt_q;
	logic [CW-1:0] l_w, r_w, lo_w, hi_w, cnt_w;
	logic [31:0]   cfg_w;
	logic          mode_ok;
	entry_t        ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_cnt_q <= IW'(RST_CNT);
		end else if (cfg_we) begin
			leaf_cnt_q <= IW'(cfg_w);
		end
	end

	always_comb begin
		cfg_w = {{(32 - IDX_W){1'b0}}, cfg_wdata};
		if (cfg_w == 32'd0) begin
			cfg_w = 32'd1;
		end else if (cfg_w > 32'(LEAVES)) begin
			cfg_w = 32'(LEAVES);
		end
	end

	always_comb begin
		l_w   = CW'(req.left);
		r_w   = CW'(req.right);
		cnt_w = CW'(leaf_cnt_q);
		lo_w  = (l_w > r_w) ? r_w : l_w;
		hi_w  = (l_w > r_w) ? l_w : r_w;
		if (lo_w == '0) begin
			lo_w = CW'(1);
		end
		if (hi_w == '0) begin
			hi_w = CW'(1);
		end
		if (lo_w > cnt_w) begin
			lo_w = cnt_w;
		end
		if (hi_w > cnt_w) begin
			hi_w = cnt_w;
		end
	end

	always_comb begin
		mode_ok = 1'b0;
		if (req.mode inside {[OP_ADD:OP_QMIN]}) begin
			mode_ok = 1'b1;
		end
	end

	assign ent.op  = req.mode;
	assign ent.lft = IW'(lo_w);
	assign ent.rgt = IW'(hi_w);
	assign ent.val = req.value;

	// unknown modes are taken and dropped here
	assign req.ready = !fifo_full && !clr_busy;
	assign push      = req.valid && req.ready && mode_ok;
	assign push_data = ent;
	assign leaf_cnt  = leaf_cnt_q;
	assign clr_start = cfg_we;
endmodule

[hw/rtl/lrat_fifo.sv]
// Two-entry queue between front end and tree engine.
module lrat_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	assign dout  = mem_q[rp_q];
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
endmodule

[hw/rtl/lrat_back.sv]
// Tree engine: walks the node RAM with an explicit stack, pushes tags, pulls sum/max/min.
module lrat_back #(
	parameter int LEAVES = 1024,
	localparam int IW    = $clog2(LEAVES + 1),
	localparam int EW    = lrat_pkg::MODE_W + 2 * IW + lrat_pkg::DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fifo_empty,
	output logic          fifo_pop,
	input  logic [EW-1:0] fifo_data,
	input  logic [IW-1:0] leaf_cnt,
	input  logic          clr_start,
	output logic          clr_busy,
	lrat_rsp_if.source    rsp
);
	import lrat_pkg::*;

	localparam int NW    = $clog2(LEAVES) + 1;
	localparam int DEPTH = 1 << NW;
	localparam int SAW   = $clog2(NW);
	localparam int NODEW = $bits(node_t);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_RD    = 5'd2;
	localparam logic [4:0] S_NODE  = 5'd3;
	localparam logic [4:0] S_WRC   = 5'd4;
	localparam logic [4:0] S_PA    = 5'd5;
	localparam logic [4:0] S_PB    = 5'd6;
	localparam logic [4:0] S_PW    = 5'd7;
	localparam logic [4:0] S_PP    = 5'd8;
	localparam logic [4:0] S_LEFT  = 5'd9;
	localparam logic [4:0] S_RIGHT = 5'd10;
	localparam logic [4:0] S_FIN   = 5'd11;
	localparam logic [4:0] S_UA    = 5'd12;
	localparam logic [4:0] S_UB    = 5'd13;
	localparam logic [4:0] S_RET   = 5'd14;
	localparam logic [4:0] S_OUT   = 5'd15;

	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [IW-1:0]     lft;
		logic [IW-1:0]     rgt;
		word_t             val;
	} entry_t;

	typedef struct packed {
		logic [NW-1:0] x;
		logic [IW-1:0] lo;
		logic [IW-1:0] hi;
		logic          nxt;
		word_t         res;
		logic          have;
	} frame_t;

	function automatic node_t apply_tags(node_t n, logic asg, word_t av, word_t t,
					     word_t prod);
		node_t o;
		o = n;
		if (asg) begin
			o.sum  = prod;
			o.mx   = av + t;
			o.mn   = av + t;
			o.tag  = t;
			o.aval = av;
			o.pend = 1'b1;
		end else begin
			o.sum = n.sum + prod;
			o.mx  = n.mx + t;
			o.mn  = n.mn + t;
			o.tag = n.tag + t;
		end
		return o;
	endfunction

	function automatic node_t pull_up(node_t a, node_t b);
		node_t o;
		o     = '0;
		o.sum = a.sum + b.sum;
		o.mx  = ($signed(a.mx) < $signed(b.mx)) ? b.mx : a.mx;
		o.mn  = ($signed(b.mn) < $signed(a.mn)) ? b.mn : a.mn;
		return o;
	endfunction

	function automatic word_t combine(logic [MODE_W-1:0] op, word_t a, word_t b);
		word_t o;
		case (op)
			OP_QMAX: o = ($signed(a) < $signed(b)) ? b : a;
			OP_QMIN: o = ($signed(b) < $signed(a)) ? b : a;
			default: o = a + b;
		endcase
		return o;
	endfunction

	logic [4:0]        state_q;
	logic [NW-1:0]     clr_q;
	logic [MODE_W-1:0] op_q;
	logic [IW-1:0]     l_q, r_q;
	word_t             v_q;
	logic [NW-1:0]     cur_x_q;
	logic [IW-1:0]     cur_lo_q, cur_hi_q;
	word_t             cur_res_q;
	logic              cur_have_q;
	word_t             ret_q;
	node_t             node_q, ch_q;
	word_t             prod_q;
	frame_t            stk_q [NW];
	logic [SAW-1:0]    sp_q;
	logic              out_v_q;
	word_t             out_d_q;

	entry_t         ent;
	node_t          rdata;
	logic [NODEW-1:0] rdata_raw;
	logic           we;
	logic [NW-1:0]  waddr, raddr;
	node_t          wdata;
	logic [IW-1:0]  mid, la, lb, len;
	logic [IW:0]    mid_sum;
	logic [NW-1:0]  ch_a, ch_b;
	logic           covered, go_left, go_right, is_query;
	word_t          mul_op;
	logic [IW-1:0]  mul_len;
	logic [SAW-1:0] spm1;
	frame_t         top_f;
	logic           out_load;
	word_t          sel_val;

	assign ent      = fifo_data;
	assign rdata    = rdata_raw;
	assign mid_sum  = {1'b0, cur_lo_q} + {1'b0, cur_hi_q};
	assign mid      = IW'(mid_sum >> 1);
	assign la       = mid - cur_lo_q + IW'(1);
	assign lb       = cur_hi_q - mid;
	assign len      = cur_hi_q - cur_lo_q + IW'(1);
	assign ch_a     = {cur_x_q[NW-2:0], 1'b0};
	assign ch_b     = {cur_x_q[NW-2:0], 1'b1};
	assign covered  = (l_q <= cur_lo_q) && (r_q >= cur_hi_q);
	assign go_left  = l_q <= mid;
	assign go_right = r_q > mid;
	assign spm1     = sp_q - 1'b1;
	assign top_f    = stk_q[spm1];
	assign clr_busy = state_q == S_CLR;
	assign fifo_pop = (state_q == S_IDLE) && !fifo_empty && !clr_start;
	assign out_load = (state_q == S_OUT) && (!out_v_q || rsp.ready);

	always_comb begin
		is_query = 1'b0;
		if (op_q inside {[OP_QSUM:OP_QMIN]}) begin
			is_query = 1'b1;
		end
	end

	always_comb begin
		case (op_q)
			OP_QMAX: sel_val = rdata.mx;
			OP_QMIN: sel_val = rdata.mn;
			default: sel_val = rdata.sum;
		endcase
	end

	always_comb begin
		case (state_q)
			S_NODE, S_FIN: raddr = ch_a;
			S_PA, S_UA:    raddr = ch_b;
			default:       raddr = cur_x_q;
		endcase
	end

	always_comb begin
		mul_op  = node_q.pend ? node_q.aval + node_q.tag : node_q.tag;
		mul_len = la;
		case (state_q)
			S_NODE: begin
				mul_op  = v_q;
				mul_len = len;
			end
			S_PB: mul_len = lb;
			default: ;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = cur_x_q;
		wdata = node_q;
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_WRC: begin
				we    = 1'b1;
				wdata = apply_tags(node_q, op_q == OP_ASG, v_q,
						   (op_q == OP_ASG) ? '0 : v_q, prod_q);
			end
			S_PB: begin
				we    = 1'b1;
				waddr = ch_a;
				wdata = apply_tags(ch_q, node_q.pend, node_q.aval, node_q.tag, prod_q);
			end
			S_PW: begin
				we    = 1'b1;
				waddr = ch_b;
				wdata = apply_tags(ch_q, node_q.pend, node_q.aval, node_q.tag, prod_q);
			end
			S_PP: begin
				we        = 1'b1;
				wdata.pend = 1'b0;
				wdata.tag  = '0;
			end
			S_UB: begin
				we    = 1'b1;
				wdata = pull_up(ch_q, rdata);
			end
			default: ;
		endcase
	end

	lrat_ram #(.W(NODEW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			sp_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (clr_start) begin
				state_q <= S_CLR;
				clr_q   <= '0;
			end else begin
				case (state_q)
					S_CLR: begin
						clr_q <= clr_q + 1'b1;
						if (&clr_q) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (!fifo_empty) begin
							sp_q    <= '0;
							state_q <= S_RD;
						end
					end
					S_RD: state_q <= S_NODE;
					S_NODE: begin
						if (!covered) begin
							state_q <= S_PA;
						end else if (is_query) begin
							state_q <= S_RET;
						end else begin
							state_q <= S_WRC;
						end
					end
					S_WRC:  state_q <= S_RET;
					S_PA:   state_q <= S_PB;
					S_PB:   state_q <= S_PW;
					S_PW:   state_q <= S_PP;
					S_PP:   state_q <= S_LEFT;
					S_LEFT: begin
						if (go_left) begin
							sp_q    <= sp_q + 1'b1;
							state_q <= S_RD;
						end else begin
							state_q <= S_RIGHT;
						end
					end
					S_RIGHT: begin
						if (go_right) begin
							sp_q    <= sp_q + 1'b1;
							state_q <= S_RD;
						end else begin
							state_q <= S_FIN;
						end
					end
					S_FIN: state_q <= is_query ? S_RET : S_UA;
					S_UA:  state_q <= S_UB;
					S_UB:  state_q <= S_RET;
					S_RET: begin
						if (sp_q == '0) begin
							state_q <= is_query ? S_OUT : S_IDLE;
						end else begin
							sp_q    <= spm1;
							state_q <= top_f.nxt ? S_FIN : S_RIGHT;
						end
					end
					S_OUT: begin
						if (out_load) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_op * DW'(mul_len);
		if (out_load) begin
			out_d_q <= ret_q;
		end
		case (state_q)
			S_IDLE: begin
				op_q       <= ent.op;
				l_q        <= ent.lft;
				r_q        <= ent.rgt;
				v_q        <= ent.val;
				cur_x_q    <= NW'(1);
				cur_lo_q   <= IW'(1);
				cur_hi_q   <= leaf_cnt;
				cur_have_q <= 1'b0;
			end
			S_NODE: begin
				node_q <= rdata;
				ret_q  <= sel_val;
			end
			S_PA, S_PB, S_UA: ch_q <= rdata;
			S_LEFT: begin
				if (go_left) begin
					stk_q[sp_q] <= '{x: cur_x_q, lo: cur_lo_q, hi: cur_hi_q, nxt: 1'b0,
							 res: cur_res_q, have: cur_have_q};
					cur_x_q     <= ch_a;
					cur_hi_q    <= mid;
					cur_have_q  <= 1'b0;
				end
			end
			S_RIGHT: begin
				if (go_right) begin
					stk_q[sp_q] <= '{x: cur_x_q, lo: cur_lo_q, hi: cur_hi_q, nxt: 1'b1,
							 res: cur_res_q, have: cur_have_q};
					cur_x_q     <= ch_b;
					cur_lo_q    <= mid + IW'(1);
					cur_have_q  <= 1'b0;
				end
			end
			S_FIN: ret_q <= cur_res_q;
			S_RET: begin
				if (sp_q != '0) begin
					cur_x_q    <= top_f.x;
					cur_lo_q   <= top_f.lo;
					cur_hi_q   <= top_f.hi;
					cur_have_q <= 1'b1;
					cur_res_q  <= top_f.have ? combine(op_q, top_f.res, ret_q) : ret_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid  = out_v_q;
	assign rsp.answer = out_d_q;
endmodule

[hw/rtl/lazy_range_add_assign_tree_unit.sv]
// Top level of the lazy range add/assign segment tree with sum, max and min queries.
//
//   channel   dir  handshake         payload
//   req       in   valid/ready       mode, left, right, value
//   rsp       out  valid/ready       answer (queries only)
//   cfg       in   cfg_we            cfg_wdata = leaf_count
//
// A split node pushes its tags to both children and, unless on a query, pulls them back
// up; a covered node is read and, on an update, rewritten. The queue is popped first and,
// on a query, rsp is loaded last; at most two split nodes per level, one node RAM access a step.
// Reset and every leaf_count write start a clearing pass over all 2**($clog2(LEAVES)+1)
// node RAM words (2048 by default) during which req is not accepted.
// A two-entry queue lets the front end take items while the engine or rsp stalls.
module lazy_range_add_assign_tree_unit #(
	parameter int LEAVES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lrat_req_if.sink                   req,
	lrat_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [lrat_pkg::IDX_W-1:0] cfg_wdata
);
	import lrat_pkg::*;

	localparam int IW = $clog2(LEAVES + 1);
	localparam int EW = MODE_W + 2 * IW + DW;

	logic          push, pop, full, empty, clr_busy, clr_start;
	logic [EW-1:0] push_data, pop_data;
	logic [IW-1:0] leaf_cnt;

	lrat_front #(.LEAVES(LEAVES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.clr_busy  (clr_busy),
		.fifo_full (full),
		.push      (push),
		.push_data (push_data),
		.leaf_cnt  (leaf_cnt),
		.clr_start (clr_start)
	);

	lrat_fifo #(.W(EW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.full   (full),
		.pop    (pop),
		.dout   (pop_data),
		.empty  (empty)
	);

	lrat_back #(.LEAVES(LEAVES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (empty),
		.fifo_pop   (pop),
		.fifo_data  (pop_data),
		.leaf_cnt   (leaf_cnt),
		.clr_start  (clr_start),
		.clr_busy   (clr_busy),
		.rsp        (rsp)
	);
endmodule

[tb/testbench.sv]
// Self-checking testbench for the lazy range add/assign segment tree unit.
`timescale 1ns / 1ps

module testbench;
	import lrat_pkg::*;

	localparam logic [MODE_W-1:0] OP_NOP5 = 3'd5;
	localparam logic [MODE_W-1:0] OP_NOP7 = 3'd7;
	localparam int MAX_LEAVES   = 1024;
	localparam int TREE_NODES   = 4 * MAX_LEAVES;
	localparam int DRAIN_CYCLES = 2000;
	localparam int LONG_HOLD    = 3000;
	localparam int IDLE_LIMIT   = 20000;
	localparam int RANDOM_ITEMS = 600;
	localparam word_t MAX_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam word_t MIN_NEG   = 64'h8000_0000_0000_0000;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		word_t             val;
		bit                typed;
		word_t             ans;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_wdata = '0;

	lrat_req_if req ();
	lrat_rsp_if rsp ();

	lazy_range_add_assign_tree_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow tree, heap order from 1
	word_t seg_sum[TREE_NODES];
	word_t seg_max[TREE_NODES];
	word_t seg_min[TREE_NODES];
	word_t seg_add[TREE_NODES];
	word_t seg_aval[TREE_NODES];
	bit    seg_apend[TREE_NODES];
	int    elem_count;

	word_t answer_q[$];
	int    fails = 0;
	int    answers_seen = 0;
	int    items_sent = 0;
	int    resizes = 0;
	bit    hold_request = 0;
	bit    done = 0;
	int    idle_cycles = 0;

	function automatic bit lt(word_t a, word_t b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic void tree_clear();
		for (int i = 0; i < TREE_NODES; i++) begin
			seg_sum[i] = '0; seg_max[i] = '0; seg_min[i] = '0;
			seg_add[i] = '0; seg_aval[i] = '0; seg_apend[i] = 0;
		end
	endfunction

	function automatic void node_add(int x, word_t len, word_t v);
		seg_sum[x] += v * len;
		seg_add[x] += v;
		seg_max[x] += v;
		seg_min[x] += v;
	endfunction

	function automatic void node_set(int x, word_t len, word_t v);
		seg_sum[x] = v * len;
		seg_add[x] = '0;
		seg_max[x] = v;
		seg_min[x] = v;
		seg_aval[x] = v;
		seg_apend[x] = 1;
	endfunction

	// pending assign goes down before the add tag
	function automatic void push_tags(int x, int lo, int hi);
		int mid;
		mid = (lo + hi) / 2;
		if (2 * x + 1 >= TREE_NODES) return;
		if (seg_apend[x]) begin
			node_set(2 * x, mid - lo + 1, seg_aval[x]);
			node_set(2 * x + 1, hi - mid, seg_aval[x]);
			seg_apend[x] = 0;
		end
		if (seg_add[x] != 0) begin
			node_add(2 * x, mid - lo + 1, seg_add[x]);
			node_add(2 * x + 1, hi - mid, seg_add[x]);
			seg_add[x] = '0;
		end
	endfunction

	function automatic void range_update(int x, int lo, int hi, int l, int r, bit asg,
			word_t v);
		int mid;
		mid = (lo + hi) / 2;
		if (x >= TREE_NODES) return;
		if (l <= lo && r >= hi) begin
			if (asg) node_set(x, hi - lo + 1, v);
			else node_add(x, hi - lo + 1, v);
			return;
		end
		if (2 * x + 1 >= TREE_NODES) return;
		push_tags(x, lo, hi);
		if (l <= mid) range_update(2 * x, lo, mid, l, r, asg, v);
		if (r > mid) range_update(2 * x + 1, mid + 1, hi, l, r, asg, v);
		seg_sum[x] = seg_sum[2 * x] + seg_sum[2 * x + 1];
		seg_max[x] = lt(seg_max[2 * x], seg_max[2 * x + 1]) ? seg_max[2 * x + 1]
			: seg_max[2 * x];
		seg_min[x] = lt(seg_min[2 * x + 1], seg_min[2 * x]) ? seg_min[2 * x + 1]
			: seg_min[2 * x];
	endfunction

	function automatic word_t range_query(int x, int lo, int hi, int l, int r,
			logic [MODE_W-1:0] op);
		int mid;
		word_t res, part;
		bit have;
		mid = (lo + hi) / 2;
		res = '0;
		have = 0;
		if (x >= TREE_NODES) return '0;
		if (l <= lo && r >= hi)
			return op == OP_QSUM ? seg_sum[x] : (op == OP_QMAX ? seg_max[x] : seg_min[x]);
		if (2 * x + 1 >= TREE_NODES) return '0;
		push_tags(x, lo, hi);
		if (l <= mid) begin
			res = range_query(2 * x, lo, mid, l, r, op);
			have = 1;
		end
		if (r > mid) begin
			part = range_query(2 * x + 1, mid + 1, hi, l, r, op);
			if (!have) res = part;
			else if (op == OP_QSUM) res = res + part;
			else if (op == OP_QMAX) res = lt(res, part) ? part : res;
			else res = lt(part, res) ? part : res;
		end
		return res;
	endfunction

	// applies one item to the shadow tree; returns 1 with the answer for queries
	function automatic bit tree_apply(logic [MODE_W-1:0] op, int l, int r, word_t v,
			output word_t ans);
		int t;
		ans = '0;
		if (l > r) begin
			t = l; l = r; r = t;
		end
		if (l < 1) l = 1;
		if (r < 1) r = 1;
		if (l > elem_count) l = elem_count;
		if (r > elem_count) r = elem_count;
		case (op)
			OP_ADD: range_update(1, 1, elem_count, l, r, 0, v);
			OP_ASG: range_update(1, 1, elem_count, l, r, 1, v);
			OP_QSUM, OP_QMAX, OP_QMIN: begin
				ans = range_query(1, 1, elem_count, l, r, op);
				return 1;
			end
			default: ;
		endcase
		return 0;
	endfunction

	task automatic report(string what, word_t got, word_t want);
		fails++;
		$display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
	endtask

	// response side: random ready, with a long hold-off on request
	initial begin
		int gap;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
				rsp.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) begin
			answers_seen++;
			if (answer_q.size() == 0) begin
				report("unexpected answer", rsp.answer, '0);
			end else begin
				if (rsp.answer !== answer_q[0]) report("answer", rsp.answer, answer_q[0]);
				void'(answer_q.pop_front());
			end
		end
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("testbench failed");
			$finish;
		end
	end

	// drive one item at the current falling edge, wait for it, then maybe idle
	task automatic send_item(logic [MODE_W-1:0] op, logic [IDX_W-1:0] l,
			logic [IDX_W-1:0] r, word_t v, bit typed, word_t want, bit allow_gap);
		word_t ans;
		int gap;
		req.valid <= 1'b1;
		req.mode <= op;
		req.left <= l;
		req.right <= r;
		req.value <= v;
		do @(posedge clk); while (!(req.valid && req.ready));
		items_sent++;
		if (tree_apply(op, l, r, v, ans)) begin
			if (typed && ans !== want) report("shadow tree vs table", ans, want);
			answer_q.insert(answer_q.size(), typed ? want : ans);
		end
		@(negedge clk);
		if (allow_gap && $urandom_range(0, 2) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic resize(logic [IDX_W-1:0] n);
		req.valid <= 1'b0;
		wait (answer_q.size() == 0);
		// adds and assigns may still be in the engine
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(negedge clk);
		cfg_we <= 1'b0;
		elem_count = (n < 1) ? 1 : ((n > MAX_LEAVES) ? MAX_LEAVES : n);
		tree_clear();
		resizes++;
	endtask

	function automatic word_t rand_value();
		case ($urandom_range(0, 5))
			0: return MAX_POS;
			1: return MIN_NEG;
			2: return {$urandom, $urandom};
			default: return word_t'($signed($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] rand_index();
		if ($urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 2047));
		return IDX_W'($urandom_range(1, elem_count));
	endfunction

	function automatic logic [MODE_W-1:0] rand_op();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0) return MODE_W'($urandom_range(5, 7));
		return (k < 8) ? ((k & 1) ? OP_ADD : OP_ASG) : (k < 12 ? OP_QSUM
			: (k < 16 ? OP_QMAX : OP_QMIN));
	endfunction

	stim_row_t rows[$];

	initial begin
		int sizes[6];
		req.valid = 1'b0;
		req.mode = OP_QSUM;
		req.left = '0;
		req.right = '0;
		req.value = '0;
		elem_count = MAX_LEAVES;
		tree_clear();

		rows = '{
			'{OP_QSUM, 1, 1024, 0, 1, 0},
			'{OP_QMAX, 1, 1024, 0, 1, 0},
			'{OP_QMIN, 0, 2047, 0, 1, 0},
			'{OP_ADD, 1, 1024, MAX_POS, 0, 0},
			'{OP_QMAX, 1, 1024, 0, 1, MAX_POS},
			'{OP_QSUM, 1, 2, 0, 1, 64'hFFFF_FFFF_FFFF_FFFE},
			'{OP_ADD, 1, 1, 1, 0, 0},
			'{OP_QMIN, 1, 1, 0, 1, MIN_NEG},
			'{OP_ASG, 5, 3, MIN_NEG, 0, 0},
			'{OP_QMIN, 3, 5, 0, 1, MIN_NEG},
			'{OP_QMAX, 5, 3, 0, 1, MIN_NEG},
			'{OP_NOP5, 1, 1024, 5, 0, 0},
			'{OP_QSUM, 2047, 1000, 0, 0, 0},
			'{OP_ASG, 1, 1024, '1, 0, 0},
			'{OP_QSUM, 1, 1024, 0, 1, 64'hFFFF_FFFF_FFFF_FC00},
			'{OP_ADD, 0, 0, 2, 0, 0},
			'{OP_QMAX, 1, 1, 0, 1, 1},
			'{OP_QMIN, 1024, 2, 0, 0, 0},
			'{OP_NOP7, 3, 9, 0, 0, 0},
			'{OP_QMAX, 512, 513, 0, 1, '1}
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send_item(rows[i].mode, rows[i].lo, rows[i].hi, rows[i].val, rows[i].typed,
				rows[i].ans, 1);

		// register extremes: 0 saturates to one element, 2047 to the full array
		sizes = '{0, 2, 7, 2047, 100, 1};
		for (int ph = 0; ph < 6; ph++) begin
			resize(IDX_W'(sizes[ph]));
			@(negedge clk);
			for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
				if (ph == 4 && i == 20) begin
					// response side holds off; requests keep coming until input stalls
					hold_request = 1;
					for (int k = 0; k < 12; k++)
						send_item(MODE_W'(int'(OP_QSUM) + k % 3), rand_index(), rand_index(),
							0, 0, 0, 0);
				end
				if (ph == 2 && i == 50) begin
					req.valid <= 1'b0;
					wait (answer_q.size() == 0);
					@(negedge clk);
				end
				send_item(rand_op(), rand_index(), rand_index(), rand_value(), 0, 0, 1);
			end
		end

		req.valid <= 1'b0;
		wait (answer_q.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		done = 1;
		$display("run covered %0d items, %0d answers checked, %0d array resizes", items_sent,
			answers_seen, resizes);
		$display("ops: add, assign, sum/max/min queries, ignored modes, wrap and clamping");
		if (fails == 0 && answer_q.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
